/* rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/mpsm_pkg.sv */
// package for the multi-pattern substring matcher
// types, sizes and command codes; depends on nothing
package mpsm_pkg;

    localparam int MAX_WORDS  = 64;
    localparam int WORD_BYTES = 64;
    localparam int PAT_BYTES  = WORD_BYTES - 1;
    localparam int IDX_W      = 6;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 6;
    localparam int CNT_W      = 7;
    localparam int SLOT_W     = $clog2(MAX_WORDS);
    localparam int BPOS_W     = $clog2(PAT_BYTES);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] word_index;
        logic [POS_W-1:0] byte_position;
        logic [7:0]       data_byte;
        logic             last;
    } in_word_t;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] matched_index;
    } out_word_t;

    // bus that runs along the cell chain, one stage per cell
    typedef struct packed {
        logic             valid;
        logic             command;
        logic             last;
        logic [IDX_W-1:0] word_index;
        logic [POS_W-1:0] byte_position;
        logic [7:0]       data_byte;
        logic             found;
        logic [IDX_W-1:0] hit;
    } chain_t;

endpackage

/* rtl/mpsm_cell.sv */
// one pattern slot of the matcher chain: pattern store, length, progress, flag
// depends on mpsm_pkg
module mpsm_cell
    import mpsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [CNT_W-1:0]      word_count,
    input  logic                  advance,
    input  chain_t                chain_in,
    output chain_t                chain_out
);

    logic [7:0]           pat_mem [PAT_BYTES];
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [PAT_BYTES-1:0] prog_reg, prog_next;
    logic                 flag_reg, flag_next;
    chain_t               out_reg, out_next;
    logic                 is_load, is_text, hit_here, occurs;
    logic [PAT_BYTES-1:0] eq_vec;
    logic [PAT_BYTES-1:0] shifted;
    logic [LEN_W-1:0]     len_eff;

    assign is_load = advance && chain_in.valid && chain_in.command == CMD_LOAD
                     && chain_in.word_index == IDX_W'(slot)
                     && chain_in.byte_position < POS_W'(PAT_BYTES);
    assign is_text = advance && chain_in.valid && chain_in.command == CMD_TEXT;

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            pat_mem[chain_in.byte_position[BPOS_W-1:0]] <= chain_in.data_byte;
        end
    end

    always_comb
    begin
        len_eff = (len_reg > LEN_W'(PAT_BYTES)) ? LEN_W'(PAT_BYTES) : len_reg;
        for (int k = 0; k < PAT_BYTES; k++)
        begin
            eq_vec[k] = (pat_mem[k] == chain_in.data_byte) && (k < int'(len_eff));
        end
        shifted = {prog_reg[PAT_BYTES-2:0], 1'b1};
        prog_next = prog_reg;
        flag_next = flag_reg;
        len_next  = len_reg;
        occurs    = 1'b0;
        if (is_load && chain_in.last)
        begin
            len_next = LEN_W'(chain_in.byte_position + 1'b1);
        end
        if (is_text)
        begin
            prog_next = shifted & eq_vec;
            occurs = (len_eff == '0) || prog_next[len_eff - 1'b1];
            flag_next = flag_reg | occurs;
            if (chain_in.last)
            begin
                prog_next = '0;
                flag_next = 1'b0;
            end
        end
        hit_here = (flag_reg | occurs) && (CNT_W'(slot) < word_count);
        out_next = chain_in;
        if (is_text && chain_in.last && !chain_in.found && hit_here)
        begin
            out_next.found = 1'b1;
            out_next.hit   = IDX_W'(slot);
        end
        if (!advance)
        begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            prog_reg  <= '0;
            flag_reg  <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            prog_reg <= prog_next;
            flag_reg <= flag_next;
            out_reg  <= out_next;
        end
    end

    assign chain_out = out_reg;

endmodule

/* rtl/multi_pattern_substring_match.sv */
// top level of the multi-pattern substring matcher: cell chain, output register
// depends on mpsm_pkg, mpsm_cell and assert_macros.svh
//
// usage
//   in channel: one word per byte; command selects pattern load or text scan.
//   a load word writes one pattern byte of slot word_index; last sets length.
//   a text word advances every slot's match state; a text word with last set
//   produces exactly one out word: match_found and the lowest matching slot.
//   user writes word_count (cfg_we/cfg_data) only while the block is idle; unenforced.
// chain and rate
//   a word walks the chain of MAX_WORDS cells and is registered in each in turn;
//   the result of a last text word is then registered in the output register.
//   one word is accepted every cycle without stall; the chain advances as a whole.
// stall
//   the whole chain freezes while the output register is full and stalled;
//   in_stall then goes high and nothing is lost or repeated.
// reset
//   lengths, progress, flags and word_count clear; pattern bytes are
//   undefined until written.
`include "assert_macros.svh"
module multi_pattern_substring_match
    import mpsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    chain_t            chain [MAX_WORDS+1];
    logic [CNT_W-1:0]  count_reg;
    logic              advance;
    logic              ov_reg, ov_next;
    out_word_t         ow_reg, ow_next;
    chain_t            tail;

    // chain moves unless the output holds an untaken result
    assign advance  = !(ov_reg && out_stall);
    assign in_stall = !advance;

    always_comb
    begin
        chain[0]               = '0;
        chain[0].valid         = in_valid;
        chain[0].command       = in_word.command;
        chain[0].last          = in_word.last;
        chain[0].word_index    = in_word.word_index;
        chain[0].byte_position = in_word.byte_position;
        chain[0].data_byte     = in_word.data_byte;
    end

    for (genvar g = 0; g < MAX_WORDS; g++)
    begin : g_cell
        mpsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .slot       (SLOT_W'(g)),
            .word_count (count_reg),
            .advance    (advance),
            .chain_in   (chain[g]),
            .chain_out  (chain[g+1])
        );
    end

    assign tail = chain[MAX_WORDS];

    always_comb
    begin
        ov_next = ov_reg && out_stall;
        ow_next = ow_reg;
        if (advance && tail.valid && tail.command == CMD_TEXT && tail.last)
        begin
            ov_next = 1'b1;
            ow_next.match_found   = tail.found;
            ow_next.matched_index = tail.found ? tail.hit : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    `ASSERT_IMPL(a_stall_holds, clk, rst_n, out_valid && out_stall, in_stall)
    `ASSERT_NEXT(a_held_result, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
    `ASSERT_IMPL(a_none_zero, clk, rst_n, out_valid && !out_word.match_found, out_word.matched_index == '0)

endmodule
